### sv/world_to_screen_project_macros.svh
// Assertion macros for the world-to-screen block.
`ifndef WORLD_TO_SCREEN_PROJECT_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECT_MACROS_SVH

// Same-cycle implication.
`define WTS_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define WTS_ASSERT_NEXT(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### sv/wts_pkg.sv
`default_nettype none
package wts_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int VP_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam logic [VP_W-1:0] VP_WIDTH_RST = 15'd1920;
  localparam logic [VP_W-1:0] VP_HEIGHT_RST = 15'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEWPORT_WIDTH  = 2'd0,
    CFG_VIEWPORT_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_POINT = 1'b1
  } action_t;

  typedef enum logic {
    MAT_VIEW = 1'b0,
    MAT_PROJ = 1'b1
  } mat_sel_t;
endpackage
`default_nettype wire

### sv/wts_in_if.sv
`default_nettype none
interface wts_in_if #(
  parameter int COORD_WIDTH = wts_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic                          matrix_select;
  logic [3:0]                    coef_index;
  logic signed [COORD_WIDTH-1:0] coef_value;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source (output valid, action, matrix_select, coef_index, coef_value,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, action, matrix_select, coef_index, coef_value,
                pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

### sv/wts_out_if.sv
`default_nettype none
interface wts_out_if #(
  parameter int COORD_WIDTH = wts_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] screen_x;
  logic signed [COORD_WIDTH-1:0] screen_y;
  logic signed [COORD_WIDTH-1:0] depth;
  logic                          divide_skipped;

  modport source (output valid, screen_x, screen_y, depth, divide_skipped,
                  input ready);
  modport sink (input valid, screen_x, screen_y, depth, divide_skipped,
                output ready);
endinterface
`default_nettype wire

### sv/wts_cfg_if.sv
`default_nettype none
interface wts_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wts_pkg::CFG_IDX_W-1:0]   index;
  logic [wts_pkg::VP_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/world_to_screen_project.sv
// Throughput: one transaction per cycle unless results stall; the quotient pipeline
// retires one bit per stage. Loads take a slot in the first stages and give no result.
// Reset (synchronous, active high): empties the pipeline, both matrices to identity,
// viewport to 1920 x 1080.
`default_nettype none
`include "world_to_screen_project_macros.svh"
module world_to_screen_project #(
  parameter int COORD_WIDTH = wts_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = wts_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  wts_in_if.sink    points,
  wts_out_if.source results,
  wts_cfg_if.sink   cfg
);
  localparam int CW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int PW = 2 * CW;
  localparam int SW = 2 * CW + 2;
  localparam int DW = CW + FB;
  localparam int MW = CW + 17;
  localparam logic signed [CW-1:0] ONEQ = {{(CW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic signed [SW-1:0] VMAX_W = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN_W = ~VMAX_W;
  localparam logic [DW:0] LIM = {{(FB+1){1'b0}}, 1'b1, {(CW-1){1'b0}}};
  localparam logic [DW-1:0] QMAX = {{(FB+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > VMAX_W) return CMAX;
    if (v < VMIN_W) return CMIN;
    return v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  logic adv;
  logic [wts_pkg::VP_W-1:0] vpw, vph;
  logic signed [CW-1:0] view_m [16];
  logic signed [CW-1:0] proj_m [16];

  // stage 0: input register
  logic v0, act0, sel0;
  logic [3:0] idx0;
  logic signed [CW-1:0] val0;
  logic signed [CW-1:0] p0 [4];
  // stage 1: view products
  logic v1, act1, sel1;
  logic [3:0] idx1;
  logic signed [CW-1:0] val1;
  logic signed [PW-1:0] vp1 [4][4];
  // stage 2: view rows
  logic v2, act2, sel2;
  logic [3:0] idx2;
  logic signed [CW-1:0] val2;
  logic signed [CW-1:0] vw2 [4];
  logic signed [CW-1:0] vw_next [4];
  // stage 3: projection products
  logic v3;
  logic signed [PW-1:0] cp3 [4][4];
  // stage 4: clip coordinates
  logic v4;
  logic signed [CW-1:0] cl4 [4];
  logic signed [CW-1:0] cl_next [4];
  // quotient pipeline, index 0 is the setup stage
  logic dvv [DW+1];
  logic dskip [DW+1];
  logic [CW-1:0] dmd [DW+1];
  logic dneg [DW+1][3];
  logic signed [CW-1:0] draw [DW+1][3];
  logic [CW-1:0] drem [DW+1][3];
  logic [DW-1:0] dquo [DW+1][3];
  logic [DW-1:0] dnum [DW+1][3];
  // fix-up stage
  logic vf, skipf;
  logic signed [CW-1:0] ndc [3];
  logic signed [CW-1:0] ndc_next [3];
  // screen products
  logic vm, skipm;
  logic signed [MW-1:0] sxp, syp;
  logic signed [CW:0] dzm;
  logic signed [CW:0] ax, ay;
  // output register
  logic ov, oskip;
  logic signed [CW-1:0] osx, osy, odz;

  assign adv = !ov || results.ready;
  assign points.ready = adv;
  assign cfg.ready = 1'b1;
  assign results.valid = ov;
  assign results.screen_x = osx;
  assign results.screen_y = osy;
  assign results.depth = odz;
  assign results.divide_skipped = oskip;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpw <= wts_pkg::VP_WIDTH_RST;
      vph <= wts_pkg::VP_HEIGHT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        wts_pkg::CFG_VIEWPORT_WIDTH:  vpw <= cfg.data;
        wts_pkg::CFG_VIEWPORT_HEIGHT: vph <= cfg.data;
        default: ;
      endcase
    end
  end

  // matrices are written as the load passes the stage that reads them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        view_m[i] <= (i % 5 == 0) ? ONEQ : '0;
        proj_m[i] <= (i % 5 == 0) ? ONEQ : '0;
      end
    end else if (adv) begin
      if (v0 && act0 == wts_pkg::ACT_LOAD && sel0 == wts_pkg::MAT_VIEW)
        view_m[idx0] <= val0;
      if (v2 && act2 == wts_pkg::ACT_LOAD && sel2 == wts_pkg::MAT_PROJ)
        proj_m[idx2] <= val2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vf <= 1'b0;
      vm <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      v0 <= points.valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2 && act2 == wts_pkg::ACT_POINT;
      v4 <= v3;
      vf <= dvv[DW];
      vm <= vf;
      ov <= vm;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      vw_next[r] = sat_w((SW'(vp1[r][0]) + SW'(vp1[r][1]) + SW'(vp1[r][2])
                          + SW'(vp1[r][3])) >>> FB);
      cl_next[r] = sat_w((SW'(cp3[r][0]) + SW'(cp3[r][1]) + SW'(cp3[r][2])
                          + SW'(cp3[r][3])) >>> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act0 <= points.action;
      sel0 <= points.matrix_select;
      idx0 <= points.coef_index;
      val0 <= points.coef_value;
      p0[0] <= points.pos_x;
      p0[1] <= points.pos_y;
      p0[2] <= points.pos_z;
      p0[3] <= ONEQ;
      act1 <= act0;
      sel1 <= sel0;
      idx1 <= idx0;
      val1 <= val0;
      for (int r = 0; r < 4; r++)
        for (int k = 0; k < 4; k++)
          vp1[r][k] <= view_m[r*4+k] * p0[k];
      act2 <= act1;
      sel2 <= sel1;
      idx2 <= idx1;
      val2 <= val1;
      vw2 <= vw_next;
      for (int r = 0; r < 4; r++)
        for (int k = 0; k < 4; k++)
          cp3[r][k] <= proj_m[r*4+k] * vw2[k];
      cl4 <= cl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dskip[0] <= cl4[3] == '0;
      dmd[0] <= mag(cl4[3]);
      for (int c = 0; c < 3; c++) begin
        dneg[0][c] <= cl4[c][CW-1] ^ cl4[3][CW-1];
        draw[0][c] <= cl4[c];
        drem[0][c] <= '0;
        dquo[0][c] <= '0;
        dnum[0][c] <= {mag(cl4[c]), {FB{1'b0}}};
      end
    end
  end

  for (genvar s = 0; s < DW; s++) begin : g_div
    logic [CW:0] r2 [3];
    logic ge [3];

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        r2[c] = {drem[s][c], dnum[s][c][DW-1]};
        ge[c] = r2[c] >= {1'b0, dmd[s]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[s+1] <= 1'b0;
      end else if (adv) begin
        dvv[s+1] <= dvv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dskip[s+1] <= dskip[s];
        dmd[s+1] <= dmd[s];
        for (int c = 0; c < 3; c++) begin
          dneg[s+1][c] <= dneg[s][c];
          draw[s+1][c] <= draw[s][c];
          drem[s+1][c] <= ge[c] ? CW'(r2[c] - {1'b0, dmd[s]}) : r2[c][CW-1:0];
          dquo[s+1][c] <= {dquo[s][c][DW-2:0], ge[c]};
          dnum[s+1][c] <= dnum[s][c] << 1;
        end
      end
    end
  end

  always_comb begin
    logic [DW:0] qa;
    logic [DW:0] nq;
    for (int c = 0; c < 3; c++) begin
      qa = {1'b0, dquo[DW][c]} + (DW+1)'(drem[DW][c] != '0);
      nq = ~qa + 1'b1;
      if (dskip[DW])
        ndc_next[c] = draw[DW][c];
      else if (dneg[DW][c])
        ndc_next[c] = (qa > LIM) ? CMIN : nq[CW-1:0];
      else
        ndc_next[c] = (dquo[DW][c] > QMAX) ? CMAX : dquo[DW][c][CW-1:0];
    end
  end

  assign ax = (CW+1)'(ndc[0]) + (CW+1)'(ONEQ);
  assign ay = (CW+1)'(ONEQ) - (CW+1)'(ndc[1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      skipf <= dskip[DW];
      ndc <= ndc_next;
      skipm <= skipf;
      sxp <= ax * $signed({1'b0, vpw});
      syp <= ay * $signed({1'b0, vph});
      dzm <= (CW+1)'(ndc[2]) + (CW+1)'(ONEQ);
      oskip <= skipm;
      osx <= sat_w(SW'(sxp) >>> 1);
      osy <= sat_w(SW'(syp) >>> 1);
      odz <= sat_w(SW'(dzm) >>> 1);
    end
  end

  `WTS_ASSERT_NEXT(a_reset_identity, clk, rst, view_m[5] == ONEQ && proj_m[10] == ONEQ)
  `WTS_ASSERT_NOW(a_accept_lands, clk, rst, 1'b1,
    !$past(points.valid && points.ready) || $past(rst) || v0)
  `WTS_ASSERT_NEXT(a_stall_holds, clk, !rst && !adv && vf, vf && $stable(ndc[0]))

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int VPW = wts_pkg::VP_W;
  localparam int LATENCY = CW + FB + 9;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic signed [127:0] ONE_Q = 128'sd65536;
  localparam logic signed [127:0] VMAX = 128'sd2147483647;
  localparam logic signed [127:0] VMIN = -128'sd2147483648;

  typedef struct {
    wts_pkg::action_t      act;
    wts_pkg::mat_sel_t     sel;
    logic [3:0]            idx;
    logic signed [CW-1:0]  coef;
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
    logic signed [CW-1:0]  pz;
  } vertex_cmd_t;

  typedef struct {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] dep;
    logic                 skipped;
  } screen_pt_t;

  logic clk;
  logic rst;
  int   cycles;
  int   errors;
  bit   steady;

  logic signed [CW-1:0] view_m[16];
  logic signed [CW-1:0] proj_m[16];
  logic [VPW-1:0]       vp_width;
  logic [VPW-1:0]       vp_height;
  screen_pt_t           pending_pts[$];

  wts_in_if  points_if();
  wts_out_if results_if();
  wts_cfg_if cfg_if();

  world_to_screen_project uut (
    .clk(clk),
    .rst(rst),
    .points(points_if),
    .results(results_if),
    .cfg(cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] sat_q(logic signed [127:0] v);
    if (v > VMAX) return VMAX[CW-1:0];
    if (v < VMIN) return VMIN[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] row_dot(logic signed [CW-1:0] m[16], int r,
                                                  logic signed [CW-1:0] v[4]);
    logic signed [127:0] acc;
    logic signed [127:0] a;
    logic signed [127:0] b;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      a = 128'(m[r*4+k]);
      b = 128'(v[k]);
      acc = acc + a * b;
    end
    return sat_q(acc >>> FB);
  endfunction

  function automatic logic signed [CW-1:0] floor_div(logic signed [CW-1:0] n,
                                                    logic signed [CW-1:0] d);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] q;
    logic signed [127:0] r;
    num = 128'(n);
    num = num <<< FB;
    den = 128'(d);
    q = num / den;
    r = num % den;
    if (r != 0 && ((num < 0) != (den < 0))) q = q - 1;
    return sat_q(q);
  endfunction

  function automatic screen_pt_t project_point(vertex_cmd_t c);
    logic signed [CW-1:0] pt[4];
    logic signed [CW-1:0] vw[4];
    logic signed [CW-1:0] cl[4];
    logic signed [CW-1:0] nx, ny, nz;
    logic signed [127:0] t, w, h;
    screen_pt_t o;
    pt[0] = c.px; pt[1] = c.py; pt[2] = c.pz; pt[3] = ONE_Q[CW-1:0];
    for (int r = 0; r < 4; r++) vw[r] = row_dot(view_m, r, pt);
    for (int r = 0; r < 4; r++) cl[r] = row_dot(proj_m, r, vw);
    o.skipped = (cl[3] == 0);
    if (o.skipped) begin
      nx = cl[0]; ny = cl[1]; nz = cl[2];
    end else begin
      nx = floor_div(cl[0], cl[3]);
      ny = floor_div(cl[1], cl[3]);
      nz = floor_div(cl[2], cl[3]);
    end
    w = 128'(vp_width);
    h = 128'(vp_height);
    t = 128'(nx);
    t = (t + ONE_Q) * w;
    o.sx = sat_q(t >>> 1);
    t = 128'(ny);
    t = (ONE_Q - t) * h;
    o.sy = sat_q(t >>> 1);
    t = 128'(nz);
    t = t + ONE_Q;
    o.dep = sat_q(t >>> 1);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    results_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    screen_pt_t e;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_pts.size() == 0) begin
        report_mismatch("unexpected transaction", results_if.screen_x, '0);
      end else begin
        e = pending_pts.pop_front();
        if (results_if.screen_x !== e.sx) report_mismatch("screen_x", results_if.screen_x, e.sx);
        if (results_if.screen_y !== e.sy) report_mismatch("screen_y", results_if.screen_y, e.sy);
        if (results_if.depth !== e.dep) report_mismatch("depth", results_if.depth, e.dep);
        if (results_if.divide_skipped !== e.skipped)
          report_mismatch("divide_skipped", CW'(results_if.divide_skipped), CW'(e.skipped));
      end
    end
  end

  task automatic send_cmd(vertex_cmd_t c);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 15) begin
        points_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    points_if.valid         <= 1'b1;
    points_if.action        <= c.act;
    points_if.matrix_select <= c.sel;
    points_if.coef_index    <= c.idx;
    points_if.coef_value    <= c.coef;
    points_if.pos_x         <= c.px;
    points_if.pos_y         <= c.py;
    points_if.pos_z         <= c.pz;
    @(posedge clk);
    while (!points_if.ready) @(posedge clk);
    if (c.act == wts_pkg::ACT_LOAD) begin
      if (c.sel == wts_pkg::MAT_PROJ) proj_m[c.idx] = c.coef;
      else view_m[c.idx] = c.coef;
    end else begin
      pending_pts.push_back(project_point(c));
    end
  endtask

  task automatic load_coef(wts_pkg::mat_sel_t sel, int idx, logic signed [CW-1:0] v);
    vertex_cmd_t c;
    c.act = wts_pkg::ACT_LOAD; c.sel = sel; c.idx = idx[3:0]; c.coef = v;
    c.px = $urandom; c.py = $urandom; c.pz = $urandom;
    send_cmd(c);
  endtask

  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z);
    vertex_cmd_t c;
    c.act = wts_pkg::ACT_POINT; c.sel = wts_pkg::mat_sel_t'($urandom_range(1));
    c.idx = 4'($urandom);
    c.coef = $urandom; c.px = x; c.py = y; c.pz = z;
    send_cmd(c);
  endtask

  // drain the pipeline; loads may still be in flight after the last result
  task automatic wait_idle();
    @(negedge clk);
    points_if.valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_viewport(wts_pkg::cfg_reg_t r, logic [VPW-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= r;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (r == wts_pkg::CFG_VIEWPORT_WIDTH) vp_width = v;
    else vp_height = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rand_coef();
    if ($urandom_range(7) == 0) return $urandom;
    return $signed(CW'($urandom_range(0, 524288))) - 262144;
  endfunction

  function automatic logic signed [CW-1:0] rand_pos();
    if ($urandom_range(7) == 0) return $urandom;
    return $signed(CW'($urandom_range(0, 13107200))) - 6553600;
  endfunction

  task automatic test_identity_extremes();
    send_point(0, 0, 0);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh00008000, -32'sh00008000, 32'sh00010000);
    send_point(-32'sh00010000, 32'sh00010000, -32'sh00010000);
    send_point(32'sh00000001, 32'shffffffff, 32'sh00000003);
  endtask

  task automatic test_clip_w();
    load_coef(wts_pkg::MAT_PROJ, 15, 0);
    send_point(32'sh00004000, -32'sh00004000, 32'sh00020000);
    send_point(32'sh7fffffff, 32'sh80000000, 0);
    load_coef(wts_pkg::MAT_PROJ, 15, 1);
    send_point(32'sh00010000, -32'sh00010000, 32'sh00000001);
    load_coef(wts_pkg::MAT_PROJ, 15, -32'sh00010000);
    send_point(32'sh00030000, -32'sh00005000, 32'sh00008000);
    load_coef(wts_pkg::MAT_PROJ, 14, -32'sh00010000);
    load_coef(wts_pkg::MAT_PROJ, 15, 0);
    send_point(32'sh00010000, 32'sh00020000, -32'sh00040000);
    send_point(32'sh00010000, 32'sh00020000, 0);
    load_coef(wts_pkg::MAT_VIEW, 3, 32'sh7fffffff);
    send_point(32'sh7fffffff, 0, -32'sh00010000);
    load_coef(wts_pkg::MAT_VIEW, 3, 0);
    load_coef(wts_pkg::MAT_PROJ, 14, 0);
    load_coef(wts_pkg::MAT_PROJ, 15, 32'sh00010000);
  endtask

  task automatic test_viewport_extremes();
    logic [VPW-1:0] sizes[3] = '{15'd0, 15'd1, 15'h7fff};
    foreach (sizes[i]) begin
      write_viewport(wts_pkg::CFG_VIEWPORT_WIDTH, sizes[i]);
      write_viewport(wts_pkg::CFG_VIEWPORT_HEIGHT, sizes[2-i]);
      send_point(32'sh00008000, -32'sh00008000, 0);
      send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    end
    write_viewport(wts_pkg::CFG_VIEWPORT_WIDTH, 15'd16384);
    write_viewport(wts_pkg::CFG_VIEWPORT_HEIGHT, 15'd16384);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20)
        load_coef(wts_pkg::mat_sel_t'($urandom_range(1)), $urandom_range(15), rand_coef());
      else
        send_point(rand_pos(), rand_pos(), rand_pos());
    end
  endtask

  task automatic test_random_stream();
    random_phase(300);
    // sender holds off until the pipeline is empty
    wait_idle();
    random_phase(50);
    write_viewport(wts_pkg::CFG_VIEWPORT_WIDTH, VPW'($urandom_range(32767)));
    write_viewport(wts_pkg::CFG_VIEWPORT_HEIGHT, VPW'($urandom_range(32767)));
    steady = 1'b1;
    random_phase(200);
    steady = 1'b0;
    random_phase(100);
    write_viewport(wts_pkg::CFG_VIEWPORT_WIDTH, 15'd1920);
    write_viewport(wts_pkg::CFG_VIEWPORT_HEIGHT, 15'd1080);
    random_phase(250);
  endtask

  initial begin
    cycles = 0;
    errors = 0;
    steady = 1'b0;
    for (int i = 0; i < 16; i++) begin
      view_m[i] = (i % 5 == 0) ? ONE_Q[CW-1:0] : '0;
      proj_m[i] = (i % 5 == 0) ? ONE_Q[CW-1:0] : '0;
    end
    vp_width  = wts_pkg::VP_WIDTH_RST;
    vp_height = wts_pkg::VP_HEIGHT_RST;
    rst = 1'b1;
    points_if.valid         = 1'b0;
    points_if.action        = wts_pkg::ACT_LOAD;
    points_if.matrix_select = wts_pkg::MAT_VIEW;
    points_if.coef_index    = '0;
    points_if.coef_value    = '0;
    points_if.pos_x         = '0;
    points_if.pos_y         = '0;
    points_if.pos_z         = '0;
    results_if.ready        = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = wts_pkg::CFG_VIEWPORT_WIDTH;
    cfg_if.data             = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_identity_extremes();
    test_clip_w();
    test_viewport_extremes();
    test_random_stream();

    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
